// ===== rtl/premultiplied_pixel_compositor_assert.svh =====
// ----------------------------------------------------------------------------
// premultiplied pixel compositor assertion macros
// shared concurrent assertion forms for the compositor checker
// ----------------------------------------------------------------------------
`ifndef PREMULTIPLIED_PIXEL_COMPOSITOR_ASSERT_SVH
`define PREMULTIPLIED_PIXEL_COMPOSITOR_ASSERT_SVH

// plain property, sampled on the rising edge, off during reset
`define PPC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// signal unchanged in the cycle after a condition
`define PPC_ASSERT_HOLD(lbl, ck, rs, cond, sig, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) cond |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg
// types, constants and channel arithmetic shared by the compositor modules
// ----------------------------------------------------------------------------
package ppc_pkg;

  // field widths
  localparam int OP_W       = 3;
  localparam int PIX_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // stream word layout
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 40;

  // operation codes
  localparam logic [OP_W-1:0] OP_FILL     = 3'd0;
  localparam logic [OP_W-1:0] OP_BLEND    = 3'd1;
  localparam logic [OP_W-1:0] OP_COLORMOD = 3'd2;
  localparam logic [OP_W-1:0] OP_COPY     = 3'd3;
  localparam logic [OP_W-1:0] OP_RGB565   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT       = 3'd4;

  // register reset values
  localparam logic [7:0]  FILL_RESET = 8'hff;
  localparam logic [23:0] TINT_RESET = 24'hffffff;

  // what the second stage does with the prepared colour
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PASS,
    KIND_OVER
  } kind_t;

  // configuration register bank
  typedef struct packed {
    logic [7:0]  fill_red;
    logic [7:0]  fill_green;
    logic [7:0]  fill_blue;
    logic [7:0]  fill_alpha;
    logic [23:0] tint;
  } cfg_t;

  // prepared item handed from the first to the second stage
  typedef struct packed {
    kind_t            kind;
    logic [PIX_W-1:0] color;
    logic [7:0]       da;
    logic [PIX_W-1:0] dst;
  } prep_t;

  // channel scale: (c*k)>>8
  function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] k);
    logic [15:0] p;
    p = c * k;
    return p[15:8];
  endfunction

  // channel premultiply: ((c+1)*a)>>8
  function automatic logic [7:0] premul8(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] p;
    p = ({1'b0, c} + 9'd1) * a;
    return p[15:8];
  endfunction

endpackage

// ===== rtl/ppc_cfg.sv =====
// ----------------------------------------------------------------------------
// ppc_cfg
// fill colour and tint registers behind the write port
// ----------------------------------------------------------------------------
module ppc_cfg
  import ppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_red   <= FILL_RESET;
      cfg.fill_green <= FILL_RESET;
      cfg.fill_blue  <= FILL_RESET;
      cfg.fill_alpha <= FILL_RESET;
      cfg.tint       <= TINT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILL_RED:   cfg.fill_red   <= cfg_data[7:0];
        CFG_FILL_GREEN: cfg.fill_green <= cfg_data[7:0];
        CFG_FILL_BLUE:  cfg.fill_blue  <= cfg_data[7:0];
        CFG_FILL_ALPHA: cfg.fill_alpha <= cfg_data[7:0];
        CFG_TINT:       cfg.tint       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ppc_prep.sv =====
// ----------------------------------------------------------------------------
// ppc_prep
// first stage: decodes the operation and builds the colour to draw
// ----------------------------------------------------------------------------
module ppc_prep
  import ppc_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [OP_W-1:0]  op,
  input  logic [PIX_W-1:0] src_pixel,
  input  logic [PIX_W-1:0] dst_pixel,
  output prep_t            prep
);

  logic [PIX_W-1:0] fill_color;
  logic [23:0]      tint_scaled;
  logic [7:0]       src_alpha;
  logic [7:0]       glyph_alpha;

  // premultiplied fill colour
  assign fill_color = {cfg.fill_alpha,
                       premul8(cfg.fill_red,   cfg.fill_alpha),
                       premul8(cfg.fill_green, cfg.fill_alpha),
                       premul8(cfg.fill_blue,  cfg.fill_alpha)};

  // tint scaled by glyph alpha
  assign glyph_alpha = src_pixel[7:0];
  assign tint_scaled = {scale8(cfg.tint[23:16], glyph_alpha),
                        scale8(cfg.tint[15:8],  glyph_alpha),
                        scale8(cfg.tint[7:0],   glyph_alpha)};

  assign src_alpha = src_pixel[31:24];

  // operation decode
  always_comb begin
    prep.kind  = KIND_NONE;
    prep.color = '0;
    prep.da    = '0;
    prep.dst   = dst_pixel;
    case (op)
      OP_FILL: begin
        prep.color = fill_color;
        prep.da    = ~cfg.fill_alpha;
        if (cfg.fill_alpha == 8'hff) begin
          prep.kind = KIND_PASS;
        end else if (cfg.fill_alpha != 8'h00) begin
          prep.kind = KIND_OVER;
        end
      end
      OP_BLEND: begin
        prep.da = ~src_alpha;
        if (src_alpha == 8'hff) begin
          prep.kind  = KIND_PASS;
          prep.color = {8'h00, src_pixel[23:0]};
        end else if (src_alpha != 8'h00) begin
          prep.kind  = KIND_OVER;
          prep.color = src_pixel;
        end
      end
      OP_COLORMOD: begin
        prep.color = {8'h00, tint_scaled};
        prep.da    = ~glyph_alpha;
        if (glyph_alpha == 8'hff) begin
          prep.kind = KIND_PASS;
        end else if (glyph_alpha != 8'h00) begin
          prep.kind = KIND_OVER;
        end
      end
      OP_COPY: begin
        prep.kind  = KIND_PASS;
        prep.color = src_pixel;
      end
      OP_RGB565: begin
        prep.kind  = KIND_PASS;
        prep.color = {16'h0000, src_pixel[23:19], src_pixel[15:10], src_pixel[7:3]};
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/ppc_over.sv =====
// ----------------------------------------------------------------------------
// ppc_over
// second stage: source-over blend of the prepared colour onto the destination
// ----------------------------------------------------------------------------
module ppc_over
  import ppc_pkg::*;
(
  input  prep_t            prep,
  output logic [PIX_W-1:0] out_pixel,
  output logic             write_enable
);

  logic [PIX_W-1:0] dst_scaled;
  logic [PIX_W-1:0] blended;

  // destination channels scaled by inverse alpha, destination alpha dropped
  assign dst_scaled = {8'h00,
                       scale8(prep.dst[23:16], prep.da),
                       scale8(prep.dst[15:8],  prep.da),
                       scale8(prep.dst[7:0],   prep.da)};

  // channel sums carry into the next channel, wrap at 32 bits
  assign blended = dst_scaled + {8'h00, prep.color[23:0]};

  // result select
  always_comb begin
    case (prep.kind)
      KIND_PASS: begin
        out_pixel    = prep.color;
        write_enable = 1'b1;
      end
      KIND_OVER: begin
        out_pixel    = blended;
        write_enable = 1'b1;
      end
      default: begin
        out_pixel    = '0;
        write_enable = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/premultiplied_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// premultiplied_pixel_compositor
// per-pixel argb8888 compositor: fill, premultiplied blend, glyph colormod,
// copy and rgb565 pack
//
//   channel  dir  fields (low bit up)
//   s_*      in   tdata: op[2:0] src_pixel[34:3] dst_pixel[66:35], zero pad
//   m_*      out  tdata: out_pixel[31:0] write_enable[32], zero pad
//   cfg_*    in   write enable, register index, data
//
// one pixel per cycle unless m_tready stalls; three register stages (input,
// prepare, result), which a taken word passes in order before m_tvalid rises
// the two multiply layers (colour build, destination scale) set the stage split
// rst clears all valid bits and loads the register reset values
// a stall on m_tready fills empty stages before s_tready drops
// ----------------------------------------------------------------------------
module premultiplied_pixel_compositor
  import ppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // op, src_pixel, dst_pixel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // out_pixel, write_enable
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic             v1;
  logic             v2;
  logic             v3;
  logic             adv1;
  logic             adv2;
  logic             adv3;
  logic [OP_W-1:0]  op;
  logic [PIX_W-1:0] src_pixel;
  logic [PIX_W-1:0] dst_pixel;
  prep_t            prep_next;
  prep_t            prep;
  logic [PIX_W-1:0] out_pixel_next;
  logic             write_enable_next;
  logic [PIX_W-1:0] out_pixel;
  logic             write_enable;

  ppc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage moves: a stage loads when it is empty or its contents move on
  assign adv3     = !v3 || m_tready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv1 && s_tvalid) begin
      op        <= s_tdata[2:0];
      src_pixel <= s_tdata[34:3];
      dst_pixel <= s_tdata[66:35];
    end
  end

  ppc_prep u_prep (
    .cfg       (cfg),
    .op        (op),
    .src_pixel (src_pixel),
    .dst_pixel (dst_pixel),
    .prep      (prep_next)
  );

  // prepare register
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      prep <= prep_next;
    end
  end

  ppc_over u_over (
    .prep         (prep),
    .out_pixel    (out_pixel_next),
    .write_enable (write_enable_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      out_pixel    <= out_pixel_next;
      write_enable <= write_enable_next;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {7'd0, write_enable, out_pixel};

endmodule

// ===== rtl/ppc_checker.sv =====
// ----------------------------------------------------------------------------
// ppc_checker
// port-level checks on the compositor, bound to the top level
// ----------------------------------------------------------------------------
`include "premultiplied_pixel_compositor_assert.svh"

module ppc_checker
  import ppc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_DATA_W-1:0]   m_tdata    // out_pixel, write_enable
);

  // a stalled result stays offered
  `PPC_ASSERT(a_m_valid_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped under stall")

  // a stalled result keeps its word
  `PPC_ASSERT_HOLD(a_m_data_hold, clk, rst, m_tvalid && !m_tready, m_tdata, "m_tdata changed under stall")

  // a skipped write carries a zero pixel
  `PPC_ASSERT(a_no_write_zero, clk, rst, m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0, "pixel not zero on skipped write")

  // with the sink ready, a taken word is offered on m_tvalid once through the input, prepare and result registers
  `PPC_ASSERT(a_latency, clk, rst, s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid, "result missing after pipeline latency")

endmodule

bind premultiplied_pixel_compositor ppc_checker u_ppc_checker (.*);

// ===== bench/pixel_composite_checker.sv =====
// ----------------------------------------------------------------------------
// pixel composite checker
// watches the pixel stream, the result stream and the register port of the
// compositor, works out the new destination pixel for every accepted word
// and compares each result word field by field with the oldest prediction
// ----------------------------------------------------------------------------
module pixel_composite_checker
  import ppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // op, src_pixel, dst_pixel
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,   // out_pixel, write_enable
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    written
);
  timeunit 1ns;
  timeprecision 1ps;

  // channel masks of an argb8888 word
  localparam logic [31:0] RB_MASK    = 32'h00ff00ff;
  localparam logic [31:0] G_MASK     = 32'h0000ff00;
  localparam logic [31:0] RGB_MASK   = 32'h00ffffff;
  localparam logic [31:0] ALPHA_MASK = 32'hff000000;

  // field offsets in the pixel word
  localparam int SRC_LSB = OP_W;
  localparam int DST_LSB = OP_W + PIX_W;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             wr;
  } pixel_result_t;

  // local copy of the register bank
  logic [7:0]  fill_red;
  logic [7:0]  fill_green;
  logic [7:0]  fill_blue;
  logic [7:0]  fill_alpha;
  logic [23:0] tint;

  pixel_result_t pending_pixels[$];
  int n_errors;
  int n_checked;
  int n_written;

  // ((c+1)*a)>>8
  function automatic logic [7:0] premultiply(input logic [7:0] c, input logic [7:0] a);
    logic [31:0] p;
    p = ({24'b0, c} + 32'd1) * {24'b0, a};
    return p[15:8];
  endfunction

  // premultiplied colour s over destination d, destination scaled by da
  function automatic logic [31:0] draw_over(input logic [31:0] d, input logic [31:0] s,
                                            input logic [7:0] da);
    logic [31:0] k;
    logic [31:0] rb;
    logic [31:0] g;
    k  = {24'b0, da};
    rb = (((d & RB_MASK) * k) >> 8) & RB_MASK;
    g  = (((d & G_MASK) * k) >> 8) & G_MASK;
    return rb + (s & RB_MASK) + g + (s & G_MASK);
  endfunction

  // new destination pixel and write enable for one word
  function automatic pixel_result_t composite(input logic [OP_W-1:0] op,
                                              input logic [31:0] src,
                                              input logic [31:0] dst);
    pixel_result_t r;
    logic [31:0]   color;
    logic [31:0]   ga;
    logic [31:0]   srb;
    logic [31:0]   sg;
    r.pixel = '0;
    r.wr    = 1'b0;
    case (op)
      OP_FILL: begin
        color = {fill_alpha, premultiply(fill_red, fill_alpha),
                 premultiply(fill_green, fill_alpha), premultiply(fill_blue, fill_alpha)};
        if (fill_alpha == 8'hff) begin
          r.pixel = color;
          r.wr    = 1'b1;
        end else if (fill_alpha != 8'h00) begin
          r.pixel = draw_over(dst, color, 8'hff - fill_alpha);
          r.wr    = 1'b1;
        end
      end
      OP_BLEND: begin
        // transparent source skips, opaque source copies rgb
        if (src > RGB_MASK) begin
          if (src < ALPHA_MASK)
            r.pixel = draw_over(dst, src, 8'hff - src[31:24]);
          else
            r.pixel = src & RGB_MASK;
          r.wr = 1'b1;
        end
      end
      OP_COLORMOD: begin
        ga = {24'b0, src[7:0]};
        if (ga != 32'd0) begin
          srb = ((ga * ({8'b0, tint} & RB_MASK)) >> 8) & RB_MASK;
          sg  = ((ga * ({8'b0, tint} & G_MASK)) >> 8) & G_MASK;
          if (src[7:0] != 8'hff)
            r.pixel = draw_over(dst, srb | sg, 8'hff - src[7:0]);
          else
            r.pixel = srb + sg;
          r.wr = 1'b1;
        end
      end
      OP_COPY: begin
        r.pixel = src;
        r.wr    = 1'b1;
      end
      OP_RGB565: begin
        r.pixel = {16'b0, src[23:19], src[15:10], src[7:3]};
        r.wr    = 1'b1;
      end
      default: begin
        // spare op codes write nothing
        r.pixel = '0;
        r.wr    = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", n_checked, what, got, want);
    n_errors++;
  endtask

  // sample all channels on the rising edge
  always @(posedge clk) begin
    pixel_result_t want;
    logic [31:0]   got_pixel;
    logic          got_wr;
    if (rst) begin
      fill_red   = FILL_RESET;
      fill_green = FILL_RESET;
      fill_blue  = FILL_RESET;
      fill_alpha = FILL_RESET;
      tint       = TINT_RESET;
      pending_pixels.delete();
      pending <= 0;
    end else begin
      // predict each accepted pixel word
      if (s_tvalid && s_tready)
        pending_pixels.push_back(composite(s_tdata[OP_W-1:0],
                                           s_tdata[SRC_LSB +: PIX_W],
                                           s_tdata[DST_LSB +: PIX_W]));
      // compare each accepted result word
      if (m_tvalid && m_tready) begin
        got_pixel = m_tdata[PIX_W-1:0];
        got_wr    = m_tdata[PIX_W];
        if (pending_pixels.size() == 0) begin
          report_mismatch("result with no word pending", got_pixel, '0);
        end else begin
          want = pending_pixels.pop_front();
          if (got_pixel !== want.pixel)
            report_mismatch("out_pixel", got_pixel, want.pixel);
          if (got_wr !== want.wr)
            report_mismatch("write_enable", {31'b0, got_wr}, {31'b0, want.wr});
          n_checked++;
          if (want.wr)
            n_written++;
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILL_RED:   fill_red   = cfg_data[7:0];
          CFG_FILL_GREEN: fill_green = cfg_data[7:0];
          CFG_FILL_BLUE:  fill_blue  = cfg_data[7:0];
          CFG_FILL_ALPHA: fill_alpha = cfg_data[7:0];
          CFG_TINT:       tint       = cfg_data;
          default:        ;
        endcase
      end
      pending <= pending_pixels.size();
    end
    fail_count <= n_errors;
    checked    <= n_checked;
    written    <= n_written;
  end

endmodule

// ===== bench/tb_premultiplied_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// premultiplied pixel compositor testbench
// drives directed and random pixel words through the compositor under
// several register settings, with random stalls on both streams, a long
// receiver hold-off and a drained pause per setting; the checker predicts
// and compares, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module tb_premultiplied_pixel_compositor;
  timeunit 1ns;
  timeprecision 1ps;
  import ppc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 38;
  localparam int PHASES        = 7;
  localparam int PHASE_WORDS   = 200;
  localparam int HOLD_CYCLES   = 50;
  localparam int HOLD_WORDS    = 40;
  localparam int SETTLE_CYCLES = 8;

  // codes beyond the defined lists
  localparam logic [OP_W-1:0]      OP_SPARE_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

  localparam int PAD_W = S_DATA_W - OP_W - 2 * PIX_W;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int written;
  int words_sent;
  int settings_applied;
  int cycle_count;

  // idling controls: src_steady for the sender, the sink ones shared with the receiver process
  bit src_steady;
  bit sink_steady;
  bit sink_hold_req;

  premultiplied_pixel_compositor uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_composite_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .written    (written)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin : sink_proc
    int held;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
      end else begin
        m_tready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // alpha with weight on the edge values
  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)      return 8'h00;
    else if (r < 30) return 8'hff;
    else if (r < 36) return 8'h01;
    else if (r < 42) return 8'hfe;
    else             return 8'($urandom);
  endfunction

  // pixel with weight on all zeros and all ones
  function automatic logic [31:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)       return 32'h00000000;
    else if (r < 16) return 32'hffffffff;
    else             return $urandom;
  endfunction

  // offer one word after a random gap, wait for the handshake
  task automatic send_pixel(input logic [OP_W-1:0] op, input logic [31:0] src,
                            input logic [31:0] dst);
    @(negedge clk);
    while (!src_steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, dst, src, op};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    words_sent++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do
      @(posedge clk);
    while (pending != 0);
  endtask

  // write all registers plus one spare index, upper data bits random
  task automatic set_registers(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [7:0] a, input logic [23:0] t);
    logic [CFG_DATA_W-9:0] junk;
    junk = (CFG_DATA_W-8)'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILL_RED;
    cfg_data  <= {junk, r};
    @(negedge clk);
    cfg_index <= CFG_FILL_GREEN;
    cfg_data  <= {~junk, g};
    @(negedge clk);
    cfg_index <= CFG_FILL_BLUE;
    cfg_data  <= {junk, b};
    @(negedge clk);
    cfg_index <= CFG_FILL_ALPHA;
    cfg_data  <= {~junk, a};
    @(negedge clk);
    cfg_index <= CFG_TINT;
    cfg_data  <= t;
    @(negedge clk);
    cfg_index <= CFG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2));
    cfg_data  <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // stimulus and verdict
  initial begin : main_proc
    int phase;
    int n;
    int k;
    int pick;
    logic [OP_W-1:0] op;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  fr;
    logic [7:0]  fg;
    logic [7:0]  fb;
    logic [23:0] tint;

    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    src_steady       = 1'b0;
    sink_steady      = 1'b0;
    sink_hold_req    = 1'b0;
    words_sent       = 0;
    settings_applied = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words under the reset register values
    send_pixel(OP_FILL, 32'h00000000, 32'h12345678);
    send_pixel(OP_BLEND, 32'h00000000, 32'hffffffff);
    send_pixel(OP_BLEND, 32'h00ffffff, 32'hffffffff);
    send_pixel(OP_BLEND, 32'h01000000, 32'hffffffff);
    send_pixel(OP_BLEND, 32'hfeffffff, 32'hffffffff);
    send_pixel(OP_BLEND, 32'hff000000, 32'h00000000);
    send_pixel(OP_BLEND, 32'hffffffff, 32'h00000000);
    // carries run from one channel into the next
    send_pixel(OP_BLEND, 32'h80ffffff, 32'hffffffff);
    // glyph alpha of zero with the unused bits set
    send_pixel(OP_COLORMOD, 32'hffffff00, 32'hffffffff);
    send_pixel(OP_COLORMOD, 32'h00000001, 32'hffffffff);
    send_pixel(OP_COLORMOD, 32'h000000ff, 32'h00000000);
    send_pixel(OP_COLORMOD, 32'h00000080, 32'hffffffff);
    send_pixel(OP_COPY, 32'h00000000, 32'hffffffff);
    send_pixel(OP_COPY, 32'hffffffff, 32'h00000000);
    send_pixel(OP_RGB565, 32'hffffffff, 32'h00000000);
    send_pixel(OP_RGB565, 32'hff070307, 32'hffffffff);
    send_pixel(OP_RGB565, 32'h00f8fcf8, 32'h00000000);
    for (k = 0; k < 3; k++)
      send_pixel(OP_SPARE_FIRST + OP_W'(k), 32'hffffffff, 32'hffffffff);

    // fill and tint at a mid alpha
    drain();
    set_registers(8'hff, 8'h00, 8'h80, 8'h80, 24'h00ff00);
    send_pixel(OP_FILL, 32'h00000000, 32'hffffffff);
    send_pixel(OP_FILL, 32'hffffffff, 32'h00000000);
    send_pixel(OP_COLORMOD, 32'h00000080, 32'hffffffff);

    // random phases, one register setting each
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      fr   = 8'($urandom);
      fg   = 8'($urandom);
      fb   = 8'($urandom);
      tint = 24'($urandom);
      case (phase)
        0:       set_registers(8'h00, 8'h00, 8'h00, 8'h00, 24'h000000);
        1:       set_registers(8'hff, 8'hff, 8'hff, 8'hff, 24'hffffff);
        2:       set_registers(fr, fg, fb, 8'hff, tint);
        3:       set_registers(fr, fg, fb, 8'h01, tint);
        4:       set_registers(fr, fg, fb, 8'hfe, tint);
        default: set_registers(fr, fg, fb, pick_alpha(), tint);
      endcase

      // one phase with no idling on either side
      src_steady  = (phase == 2);
      sink_steady = (phase == 2);
      // one phase opens with a long receiver hold-off
      if (phase == 3) begin
        src_steady    = 1'b1;
        sink_hold_req = 1'b1;
      end

      for (n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 3 && n == HOLD_WORDS)
          src_steady = 1'b0;
        pick = $urandom_range(0, 99);
        dst  = pick_pixel();
        if (pick < 20) begin
          op  = OP_FILL;
          src = pick_pixel();
        end else if (pick < 50) begin
          op  = OP_BLEND;
          src = {pick_alpha(), 24'($urandom)};
        end else if (pick < 70) begin
          op  = OP_COLORMOD;
          src = {24'($urandom), pick_alpha()};
        end else if (pick < 80) begin
          op  = OP_COPY;
          src = pick_pixel();
        end else if (pick < 92) begin
          op  = OP_RGB565;
          src = pick_pixel();
        end else begin
          op  = OP_SPARE_FIRST + OP_W'($urandom_range(0, 2));
          src = pick_pixel();
        end
        send_pixel(op, src, dst);
      end
    end

    // wait out the pipeline, then give the verdict
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("sent %0d pixel words over %0d register settings, checked %0d results",
             words_sent, settings_applied, checked);
    $display("%0d results carried a write, %0d mismatches", written, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
